/* design/tttr_dec_pkg.sv */
// shared types, constants and register codes for the time-tag record decoder
package tttr_dec_pkg;

   localparam int unsigned ABS_TIME_BITS_DEF = 28;
   localparam int unsigned DELAY_BITS_DEF    = 12;
   localparam int unsigned SYNC_BITS_DEF     = 16;

   localparam int unsigned CHAN_W  = 4;
   localparam int unsigned RES_W   = 32;
   localparam int unsigned STEP_W  = 32;
   localparam int unsigned MASK_W  = 28;
   localparam int unsigned WIDE_W  = 64;
   localparam int unsigned HALF_W  = 32;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 32;

   // depth of the result queue, also the number of items allowed in flight
   localparam int unsigned QUEUE_DEPTH = 8;

   localparam logic [CHAN_W-1:0] SPECIAL_CHANNEL = 4'b1111;

   localparam logic              MODE_RESET = 1'b0;
   localparam logic [RES_W-1:0]  RES_RESET  = 32'd4;
   localparam logic [STEP_W-1:0] STEP_RESET = 32'd65536;
   localparam logic [MASK_W-1:0] MASK_RESET = 28'd585;

   typedef enum logic [1:0] {
      KIND_PHOTON   = 2'd0,
      KIND_MARKER   = 2'd1,
      KIND_OVERFLOW = 2'd2
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE = 2'd0,
      CSR_RES  = 2'd1,
      CSR_STEP = 2'd2,
      CSR_MASK = 2'd3
   } csr_index_type;

   typedef enum logic {
      MODE_T2 = 1'b0,
      MODE_T3 = 1'b1
   } mode_type;

   typedef struct packed {
      mode_type          mode;
      logic [RES_W-1:0]  resolution;
      logic [STEP_W-1:0] step;
      logic [MASK_W-1:0] mask;
   } cfg_type;

   // front stage to multiply stage
   typedef struct packed {
      logic              valid;
      kind_type          kind;
      logic [CHAN_W-1:0] channel;
      logic [WIDE_W-1:0] mul_a;
      logic [RES_W-1:0]  mul_b;
      logic [WIDE_W-1:0] pulse;
      logic [WIDE_W-1:0] ovf_total;
   } stage_type;

   typedef struct packed {
      kind_type          kind;
      logic [CHAN_W-1:0] channel;
      logic [WIDE_W-1:0] time_ps;
      logic [WIDE_W-1:0] pulse;
      logic [WIDE_W-1:0] ovf_total;
   } result_type;

endpackage

/* design/tttr_dec_req_if.sv */
// record channel into the decoder
interface tttr_dec_req_if #(
   parameter int unsigned ABS_TIME_BITS = tttr_dec_pkg::ABS_TIME_BITS_DEF,
   parameter int unsigned DELAY_BITS    = tttr_dec_pkg::DELAY_BITS_DEF,
   parameter int unsigned SYNC_BITS     = tttr_dec_pkg::SYNC_BITS_DEF
) ();
   logic                              valid;
   logic                              ready;
   logic [tttr_dec_pkg::CHAN_W-1:0]   chan_field;
   logic [ABS_TIME_BITS-1:0]          abs_time_field;
   logic [DELAY_BITS-1:0]             delay_field;
   logic [SYNC_BITS-1:0]              sync_field;

   modport source (
      output valid, chan_field, abs_time_field, delay_field, sync_field,
      input  ready
   );
   modport sink (
      input  valid, chan_field, abs_time_field, delay_field, sync_field,
      output ready
   );
endinterface

/* design/tttr_dec_rsp_if.sv */
// decoded result channel out of the decoder
interface tttr_dec_rsp_if ();
   logic                              valid;
   logic                              ready;
   logic [1:0]                        record_kind;
   logic [tttr_dec_pkg::CHAN_W-1:0]   out_channel;
   logic [tttr_dec_pkg::WIDE_W-1:0]   time_ps;
   logic [tttr_dec_pkg::WIDE_W-1:0]   pulse_count;
   logic [tttr_dec_pkg::WIDE_W-1:0]   overflow_total;

   modport source (
      output valid, record_kind, out_channel, time_ps, pulse_count, overflow_total,
      input  ready
   );
   modport sink (
      input  valid, record_kind, out_channel, time_ps, pulse_count, overflow_total,
      output ready
   );
endinterface

/* design/tttr_dec_front.sv */
// record classification, origin and overflow count, multiplier operand select
module tttr_dec_front #(
   parameter int unsigned ABS_TIME_BITS = tttr_dec_pkg::ABS_TIME_BITS_DEF,
   parameter int unsigned DELAY_BITS    = tttr_dec_pkg::DELAY_BITS_DEF,
   parameter int unsigned SYNC_BITS     = tttr_dec_pkg::SYNC_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  tttr_dec_pkg::cfg_type            cfg,
   input  logic                             in_valid,
   input  logic [tttr_dec_pkg::CHAN_W-1:0]  in_chan,
   input  logic [ABS_TIME_BITS-1:0]         in_tag,
   input  logic [DELAY_BITS-1:0]            in_delay,
   input  logic [SYNC_BITS-1:0]             in_sync,
   output tttr_dec_pkg::stage_type          stage
);
   localparam int unsigned CmpW = (ABS_TIME_BITS > tttr_dec_pkg::MASK_W) ?
                                  ABS_TIME_BITS : tttr_dec_pkg::MASK_W;

   logic [tttr_dec_pkg::WIDE_W-1:0] origin_ff, origin_in;
   logic [tttr_dec_pkg::WIDE_W-1:0] count_ff, count_in;
   tttr_dec_pkg::stage_type         stage_ff, stage_in;

   logic [CmpW-1:0] tag_x, mask_x;
   logic            is_special, t2_marker, is_ovf;

   assign tag_x      = CmpW'(in_tag);
   assign mask_x     = CmpW'(cfg.mask);
   assign is_special = (in_chan == tttr_dec_pkg::SPECIAL_CHANNEL);
   assign t2_marker  = ((tag_x & mask_x) == mask_x);
   assign is_ovf     = is_special && ((cfg.mode == tttr_dec_pkg::MODE_T3) ?
                                      (in_delay == '0) : !t2_marker);

   always_comb begin
      origin_in = origin_ff;
      count_in  = count_ff;
      if (in_valid && is_ovf) begin
         origin_in = origin_ff + tttr_dec_pkg::WIDE_W'(cfg.step);
         count_in  = count_ff + tttr_dec_pkg::WIDE_W'(1);
      end
   end

   always_comb begin
      stage_in.valid     = in_valid;
      stage_in.kind      = tttr_dec_pkg::KIND_PHOTON;
      stage_in.channel   = in_chan;
      stage_in.mul_a     = '0;
      stage_in.mul_b     = '0;
      stage_in.pulse     = '0;
      stage_in.ovf_total = count_in;
      if (is_special) begin
         if (is_ovf) begin
            stage_in.kind    = tttr_dec_pkg::KIND_OVERFLOW;
            stage_in.channel = '0;
         end else begin
            stage_in.kind = tttr_dec_pkg::KIND_MARKER;
            if (cfg.mode == tttr_dec_pkg::MODE_T3) begin
               stage_in.pulse = tttr_dec_pkg::WIDE_W'(in_delay);
            end else begin
               // raw tag passes through the multiplier times one
               stage_in.mul_a = tttr_dec_pkg::WIDE_W'(in_tag);
               stage_in.mul_b = tttr_dec_pkg::RES_W'(1);
            end
         end
      end else if (cfg.mode == tttr_dec_pkg::MODE_T3) begin
         stage_in.mul_a = tttr_dec_pkg::WIDE_W'(in_delay);
         stage_in.mul_b = cfg.resolution;
         stage_in.pulse = origin_ff + tttr_dec_pkg::WIDE_W'(in_sync);
      end else begin
         stage_in.mul_a = origin_ff + tttr_dec_pkg::WIDE_W'(in_tag);
         stage_in.mul_b = cfg.resolution;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff <= '0;
         count_ff  <= '0;
         stage_ff  <= '0;
      end else begin
         origin_ff <= origin_in;
         count_ff  <= count_in;
         stage_ff  <= stage_in;
      end
   end

   assign stage = stage_ff;

endmodule

/* design/tttr_dec_mul.sv */
// split 64x32 product: two 32x32 partial products, then the recombining add
module tttr_dec_mul (
   input  logic                      clock,
   input  logic                      reset,
   input  tttr_dec_pkg::stage_type   stage,
   output logic                      out_valid,
   output tttr_dec_pkg::result_type  out_item
);
   localparam int unsigned HalfW = tttr_dec_pkg::HALF_W;

   logic                                 valid_ff;
   tttr_dec_pkg::kind_type               kind_ff;
   logic [tttr_dec_pkg::CHAN_W-1:0]      chan_ff;
   logic [tttr_dec_pkg::WIDE_W-1:0]      pulse_ff, ovf_ff;
   logic [tttr_dec_pkg::WIDE_W-1:0]      lo_ff, lo_in;
   logic [HalfW-1:0]                     hi_ff, hi_in;

   // full 32x32 lower product; operands are zero extended
   assign lo_in = tttr_dec_pkg::WIDE_W'(stage.mul_a[HalfW-1:0]) *
                  tttr_dec_pkg::WIDE_W'(stage.mul_b);
   // only the low half of the upper partial product survives mod 2^64
   assign hi_in = stage.mul_a[tttr_dec_pkg::WIDE_W-1:HalfW] * stage.mul_b;

   always_ff @(posedge clock) begin
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      kind_ff  <= stage.kind;
      chan_ff  <= stage.channel;
      pulse_ff <= stage.pulse;
      ovf_ff   <= stage.ovf_total;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= stage.valid;
      end
   end

   assign out_valid          = valid_ff;
   assign out_item.kind      = kind_ff;
   assign out_item.channel   = chan_ff;
   assign out_item.time_ps   = lo_ff + {hi_ff, {HalfW{1'b0}}};
   assign out_item.pulse     = pulse_ff;
   assign out_item.ovf_total = ovf_ff;

endmodule

/* design/tttr_dec_fifo.sv */
// result queue between the pipeline and the output handshake
module tttr_dec_fifo #(
   parameter int unsigned DEPTH = tttr_dec_pkg::QUEUE_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      wr_valid,
   input  tttr_dec_pkg::result_type  wr_item,
   input  logic                      rd_ready,
   output logic                      rd_valid,
   output tttr_dec_pkg::result_type  rd_item
);
   localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntW = $clog2(DEPTH + 1);

   tttr_dec_pkg::result_type mem_ff [DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            pop;

   assign rd_valid = (count_ff != '0);
   assign pop      = rd_valid && rd_ready;
   assign rd_item  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (wr_valid) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (wr_valid && !pop) begin
         count_in = count_ff + CntW'(1);
      end else if (pop && !wr_valid) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_valid) begin
         mem_ff[wr_ptr_ff] <= wr_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* design/tttr_record_decoder_core.sv */
// top level of the time-tag record decoder
// an accepted item passes the input, front, product and queue registers before reaching rsp
// throughput: one item per cycle while credits last; the 64x32 time product spans two stages
// an 8-entry result queue with in-flight credits keeps req_ready off the rsp side
// reset (synchronous): origin and overflow count to zero, queue emptied,
// registers back to T2 mode, 4 ps, step 65536, marker mask 585
module tttr_record_decoder_core #(
   parameter int unsigned ABS_TIME_BITS = tttr_dec_pkg::ABS_TIME_BITS_DEF,
   parameter int unsigned DELAY_BITS    = tttr_dec_pkg::DELAY_BITS_DEF,
   parameter int unsigned SYNC_BITS     = tttr_dec_pkg::SYNC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   tttr_dec_req_if.sink                         req,
   tttr_dec_rsp_if.source                       rsp,
   input  logic                                 csr_we,
   input  logic [tttr_dec_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tttr_dec_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   localparam int unsigned QueueDepth = tttr_dec_pkg::QUEUE_DEPTH;
   localparam int unsigned InflightW  = $clog2(QueueDepth + 1);

   // configuration registers
   tttr_dec_pkg::cfg_type cfg_ff, cfg_in;

   // input register
   logic                             s0_valid_ff;
   logic [tttr_dec_pkg::CHAN_W-1:0]  s0_chan_ff;
   logic [ABS_TIME_BITS-1:0]         s0_tag_ff;
   logic [DELAY_BITS-1:0]            s0_delay_ff;
   logic [SYNC_BITS-1:0]             s0_sync_ff;

   // credits: items accepted whose results are not yet taken
   logic [InflightW-1:0] inflight_ff, inflight_in;
   logic                 req_fire, rsp_fire;

   tttr_dec_pkg::stage_type  front_stage;
   logic                     mul_valid;
   tttr_dec_pkg::result_type mul_item, q_item;

   assign req.ready = (inflight_ff < InflightW'(QueueDepth));
   assign req_fire  = req.valid && req.ready;
   assign rsp_fire  = rsp.valid && rsp.ready;

   // register writes; the user must write them only while idle, the block does not enforce it
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (tttr_dec_pkg::csr_index_type'(csr_index))
            tttr_dec_pkg::CSR_MODE: begin
               cfg_in.mode = tttr_dec_pkg::mode_type'(csr_wdata[0]);
            end
            tttr_dec_pkg::CSR_RES: begin
               cfg_in.resolution = csr_wdata[tttr_dec_pkg::RES_W-1:0];
            end
            tttr_dec_pkg::CSR_STEP: begin
               cfg_in.step = csr_wdata[tttr_dec_pkg::STEP_W-1:0];
            end
            tttr_dec_pkg::CSR_MASK: begin
               cfg_in.mask = csr_wdata[tttr_dec_pkg::MASK_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_comb begin
      inflight_in = inflight_ff;
      if (req_fire && !rsp_fire) begin
         inflight_in = inflight_ff + InflightW'(1);
      end else if (rsp_fire && !req_fire) begin
         inflight_in = inflight_ff - InflightW'(1);
      end
   end

   always_ff @(posedge clock) begin
      s0_chan_ff  <= req.chan_field;
      s0_tag_ff   <= req.abs_time_field;
      s0_delay_ff <= req.delay_field;
      s0_sync_ff  <= req.sync_field;
      if (reset) begin
         s0_valid_ff           <= 1'b0;
         inflight_ff           <= '0;
         cfg_ff.mode           <= tttr_dec_pkg::mode_type'(tttr_dec_pkg::MODE_RESET);
         cfg_ff.resolution     <= tttr_dec_pkg::RES_RESET;
         cfg_ff.step           <= tttr_dec_pkg::STEP_RESET;
         cfg_ff.mask           <= tttr_dec_pkg::MASK_RESET;
      end else begin
         s0_valid_ff <= req_fire;
         inflight_ff <= inflight_in;
         cfg_ff      <= cfg_in;
      end
   end

   // classify, update origin and overflow count, pick product operands
   tttr_dec_front #(
      .ABS_TIME_BITS (ABS_TIME_BITS),
      .DELAY_BITS    (DELAY_BITS),
      .SYNC_BITS     (SYNC_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .in_valid (s0_valid_ff),
      .in_chan  (s0_chan_ff),
      .in_tag   (s0_tag_ff),
      .in_delay (s0_delay_ff),
      .in_sync  (s0_sync_ff),
      .stage    (front_stage)
   );

   // scaled time in picoseconds
   tttr_dec_mul u_mul (
      .clock     (clock),
      .reset     (reset),
      .stage     (front_stage),
      .out_valid (mul_valid),
      .out_item  (mul_item)
   );

   // results wait here; credits keep it from overfilling
   tttr_dec_fifo #(
      .DEPTH (QueueDepth)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (mul_valid),
      .wr_item  (mul_item),
      .rd_ready (rsp.ready),
      .rd_valid (rsp.valid),
      .rd_item  (q_item)
   );

   assign rsp.record_kind    = q_item.kind;
   assign rsp.out_channel    = q_item.channel;
   assign rsp.time_ps        = q_item.time_ps;
   assign rsp.pulse_count    = q_item.pulse;
   assign rsp.overflow_total = q_item.ovf_total;

`ifndef SYNTH
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= InflightW'(QueueDepth))
      else $error("more items in flight than the result queue holds");

   a_result_has_credit: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (inflight_ff != '0))
      else $error("result shown with no item in flight");

   a_credit_take: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !rsp_fire) |=> (inflight_ff == $past(inflight_ff) + InflightW'(1)))
      else $error("accepted item not counted in flight");

   a_pipe_has_credit: assert property (@(posedge clock) disable iff (reset)
      (s0_valid_ff || front_stage.valid || mul_valid) |-> (inflight_ff != '0))
      else $error("item in the pipeline with no credit taken");
`endif

endmodule

/* dv/tttr_record_decoder_checker.sv */
// result checker for the time-tag record decoder: shadows its registers and state, checks results
module tttr_record_decoder_checker
   import tttr_dec_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   tttr_dec_req_if                req,
   tttr_dec_rsp_if                rsp,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int unsigned            mismatch_count,
   output int unsigned            results_owed,
   output int unsigned            photons_seen,
   output int unsigned            markers_seen,
   output int unsigned            overflows_seen
);

   cfg_type           cfg;
   logic [WIDE_W-1:0] origin;
   logic [WIDE_W-1:0] ovf_count;
   result_type        owed_q[$];
   int unsigned       errors;
   int unsigned       n_photon;
   int unsigned       n_marker;
   int unsigned       n_overflow;

   // decode one record against the shadow registers, advancing origin and overflow count
   function automatic result_type decode_record(
      input logic [CHAN_W-1:0]            chan,
      input logic [ABS_TIME_BITS_DEF-1:0] tag,
      input logic [DELAY_BITS_DEF-1:0]    delay,
      input logic [SYNC_BITS_DEF-1:0]     sync
   );
      result_type r;
      r = '0;
      r.kind = KIND_PHOTON;
      if (cfg.mode == MODE_T2) begin
         if (chan == SPECIAL_CHANNEL) begin
            if ((tag & cfg.mask) == cfg.mask) begin
               r.kind    = KIND_MARKER;
               r.channel = SPECIAL_CHANNEL;
               r.time_ps = WIDE_W'(tag);
            end else begin
               ovf_count = ovf_count + 1;
               origin    = origin + WIDE_W'(cfg.step);
               r.kind    = KIND_OVERFLOW;
            end
         end else begin
            r.channel = chan;
            r.time_ps = (origin + WIDE_W'(tag)) * WIDE_W'(cfg.resolution);
         end
      end else begin
         if (chan == SPECIAL_CHANNEL) begin
            if (delay == '0) begin
               ovf_count = ovf_count + 1;
               origin    = origin + WIDE_W'(cfg.step);
               r.kind    = KIND_OVERFLOW;
            end else begin
               r.kind    = KIND_MARKER;
               r.channel = SPECIAL_CHANNEL;
               r.pulse   = WIDE_W'(delay);
            end
         end else begin
            r.channel = chan;
            r.time_ps = WIDE_W'(delay) * WIDE_W'(cfg.resolution);
            r.pulse   = origin + WIDE_W'(sync);
         end
      end
      r.ovf_total = ovf_count;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [WIDE_W-1:0] want,
                              input logic [WIDE_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         cfg.mode       = mode_type'(MODE_RESET);
         cfg.resolution = RES_RESET;
         cfg.step       = STEP_RESET;
         cfg.mask       = MASK_RESET;
         origin         = '0;
         ovf_count      = '0;
         owed_q.delete();
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_MODE: cfg.mode       = mode_type'(csr_wdata[0]);
               CSR_RES:  cfg.resolution = csr_wdata[RES_W-1:0];
               CSR_STEP: cfg.step       = csr_wdata[STEP_W-1:0];
               CSR_MASK: cfg.mask       = csr_wdata[MASK_W-1:0];
               default: ;
            endcase
         end
         // results first: the item taken at this edge cannot be the one coming out
         if (rsp.valid && rsp.ready) begin
            if (owed_q.size() == 0) begin
               $display("%0t: unexpected result, kind %0d channel %0d time %0d pulse %0d",
                        $time, rsp.record_kind, rsp.out_channel, rsp.time_ps,
                        rsp.pulse_count);
               errors++;
            end else begin
               want = owed_q.pop_front();
               check_field("record_kind", WIDE_W'(want.kind), WIDE_W'(rsp.record_kind));
               check_field("out_channel", WIDE_W'(want.channel), WIDE_W'(rsp.out_channel));
               check_field("time_ps", want.time_ps, rsp.time_ps);
               check_field("pulse_count", want.pulse, rsp.pulse_count);
               check_field("overflow_total", want.ovf_total, rsp.overflow_total);
               case (want.kind)
                  KIND_PHOTON: n_photon++;
                  KIND_MARKER: n_marker++;
                  default:     n_overflow++;
               endcase
            end
         end
         if (req.valid && req.ready) begin
            owed_q.push_back(decode_record(req.chan_field, req.abs_time_field,
                                           req.delay_field, req.sync_field));
         end
      end
      mismatch_count <= errors;
      results_owed   <= owed_q.size();
      photons_seen   <= n_photon;
      markers_seen   <= n_marker;
      overflows_seen <= n_overflow;
   end

endmodule

/* dv/tttr_record_decoder_core_tb.sv */
// testbench top for the time-tag record decoder: stimulus, idling, timeout and verdict
module tttr_record_decoder_core_tb;
   import tttr_dec_pkg::*;

   localparam int unsigned ABS_W  = ABS_TIME_BITS_DEF;
   localparam int unsigned DLY_W  = DELAY_BITS_DEF;
   localparam int unsigned SYNC_W = SYNC_BITS_DEF;

   localparam logic [ABS_W-1:0]  MAX_TAG   = '1;
   localparam logic [DLY_W-1:0]  MAX_DELAY = '1;
   localparam logic [SYNC_W-1:0] MAX_SYNC  = '1;
   localparam logic [MASK_W-1:0] MAX_MASK  = '1;
   localparam logic [31:0]       MAX_WORD  = '1;

   // random records after the directed part, spread over several register settings
   localparam int unsigned RANDOM_ITEMS = 1150;
   localparam int unsigned PHASES       = 8;
   // the limit leaves a wide margin over the worst case for about 1200 records (sender
   // gaps, long receiver stalls and the pipeline latency)
   localparam int unsigned CYCLE_LIMIT  = 400000;
   // quiet cycles after the last result, longer than the pipeline latency
   localparam int unsigned TAIL_CYCLES  = 12;

   typedef enum int unsigned {
      STALL_NONE,
      STALL_COIN,
      STALL_SPARSE,
      STALL_LONG
   } stall_style_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int unsigned mismatch_count;
   int unsigned results_owed;
   int unsigned photons_seen;
   int unsigned markers_seen;
   int unsigned overflows_seen;

   int unsigned     cycle_count;
   int unsigned     burst_left;
   int unsigned     items_sent;
   int unsigned     settings_used;
   stall_style_type stall_style;
   int unsigned     pattern_left;
   int unsigned     hold_left;

   // sender's own copy of the format and mask, used to steer special records
   mode_type          cur_mode;
   logic [MASK_W-1:0] cur_mask;

   tttr_dec_req_if req_ch ();
   tttr_dec_rsp_if rsp_ch ();

   tttr_record_decoder_core uut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   tttr_record_decoder_checker result_check (
      .clock          (clock),
      .reset          (reset),
      .req            (req_ch),
      .rsp            (rsp_ch),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .results_owed   (results_owed),
      .photons_seen   (photons_seen),
      .markers_seen   (markers_seen),
      .overflows_seen (overflows_seen)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // hard stop if the run hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still owed", cycle_count,
                  results_owed);
         $display("== FAIL ==");
         $finish;
      end
   end

   // receiver: switches between stall styles, each drawn at random with a random stretch length,
   // including stretches where it never stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         pattern_left <= 0;
         hold_left    <= 0;
         stall_style  <= STALL_NONE;
      end else begin
         if (pattern_left == 0) begin
            stall_style  <= stall_style_type'($urandom_range(0, 3));
            pattern_left <= $urandom_range(40, 300);
         end else begin
            pattern_left <= pattern_left - 1;
         end
         case (stall_style)
            STALL_NONE:   rsp_ch.ready <= 1'b1;
            STALL_COIN:   rsp_ch.ready <= 1'($urandom_range(0, 1));
            STALL_SPARSE: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            default: begin
               // long runs of ready low or high
               if (hold_left != 0) begin
                  hold_left <= hold_left - 1;
               end else begin
                  rsp_ch.ready <= ~rsp_ch.ready;
                  hold_left    <= $urandom_range(0, 15);
               end
            end
         endcase
      end
   end

   // offer one record and hold it until taken; bursts of random length with
   // random gaps in between, valid stays high across a burst
   task automatic send_record(input logic [CHAN_W-1:0] chan, input logic [ABS_W-1:0] tag,
                              input logic [DLY_W-1:0] delay,
                              input logic [SYNC_W-1:0] sync);
      int unsigned gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         burst_left = $urandom_range(1, 48);
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid          <= 1'b1;
      req_ch.chan_field     <= chan;
      req_ch.abs_time_field <= tag;
      req_ch.delay_field    <= delay;
      req_ch.sync_field     <= sync;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
   endtask

   // stop sending and wait for every owed result
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
   endtask

   // write all four registers back to back while the block is idle;
   // unused upper data bits carry noise
   task automatic write_config(input mode_type mode, input logic [31:0] res,
                               input logic [31:0] step, input logic [MASK_W-1:0] mask);
      wait_idle();
      csr_we    <= 1'b1;
      csr_index <= CSR_MODE;
      csr_wdata <= ($urandom() & ~32'h1) | 32'(mode);
      @(posedge clock);
      csr_index <= CSR_RES;
      csr_wdata <= res;
      @(posedge clock);
      csr_index <= CSR_STEP;
      csr_wdata <= step;
      @(posedge clock);
      csr_index <= CSR_MASK;
      csr_wdata <= {4'($urandom()), mask};
      @(posedge clock);
      csr_we   <= 1'b0;
      cur_mode = mode;
      cur_mask = mask;
      settings_used++;
   endtask

   // random records: mostly photons, about a quarter special records,
   // steered so that markers and overflows both show up in either format
   task automatic run_phase(input int unsigned count);
      logic [CHAN_W-1:0] chan;
      logic [ABS_W-1:0]  tag;
      logic [DLY_W-1:0]  delay;
      logic [SYNC_W-1:0] sync;
      repeat (count) begin
         tag   = ABS_W'($urandom());
         delay = DLY_W'($urandom());
         sync  = SYNC_W'($urandom());
         if ($urandom_range(0, 3) == 0) begin
            chan = SPECIAL_CHANNEL;
            if ($urandom_range(0, 1) == 1) begin
               if (cur_mode == MODE_T2) tag = tag | cur_mask;
               else delay = '0;
            end
         end else begin
            chan = CHAN_W'($urandom_range(0, 14));
         end
         send_record(chan, tag, delay, sync);
      end
   endtask

   initial begin
      logic [31:0]       res;
      logic [31:0]       step;
      logic [MASK_W-1:0] mask;

      reset                 <= 1'b1;
      csr_we                <= 1'b0;
      csr_index             <= CSR_MODE;
      csr_wdata             <= '0;
      req_ch.valid          <= 1'b0;
      req_ch.chan_field     <= '0;
      req_ch.abs_time_field <= '0;
      req_ch.delay_field    <= '0;
      req_ch.sync_field     <= '0;
      burst_left            = 0;
      items_sent            = 0;
      settings_used         = 1;
      cur_mode              = mode_type'(MODE_RESET);
      cur_mask              = MASK_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: reset settings, T2 with the default marker mask
      send_record(4'd0, '0, '0, '0);                      // photon at time zero
      send_record(4'd14, MAX_TAG, MAX_DELAY, MAX_SYNC);   // highest photon channel and tag
      send_record(SPECIAL_CHANNEL, ABS_W'(585), '0, '0);  // tag equals the mask: marker
      send_record(SPECIAL_CHANNEL, MAX_TAG, '0, '0);      // all tag bits set: marker
      send_record(SPECIAL_CHANNEL, '0, MAX_DELAY, '0);    // overflow
      send_record(SPECIAL_CHANNEL, ABS_W'(584), '0, '0);  // one mask bit missing: overflow
      send_record(4'd7, MAX_TAG, '0, '0);                 // photon on a moved origin

      // T3 with the largest resolution and step
      write_config(MODE_T3, MAX_WORD, MAX_WORD, MASK_RESET);
      send_record(4'd3, '0, MAX_DELAY, MAX_SYNC);         // photon, largest delay and sync
      send_record(SPECIAL_CHANNEL, MAX_TAG, '0, MAX_SYNC); // zero delay: overflow
      send_record(SPECIAL_CHANNEL, '0, DLY_W'(1), '0);    // smallest marker
      send_record(SPECIAL_CHANNEL, '0, MAX_DELAY, MAX_SYNC); // largest marker
      send_record(4'd0, MAX_TAG, '0, '0);                 // photon with zero delay
      send_record(SPECIAL_CHANNEL, '0, '0, '0);           // another overflow
      send_record(4'd9, '0, MAX_DELAY, MAX_SYNC);         // photon on a large origin

      // T2, zero mask turns every special record into a marker; zero resolution and step
      write_config(MODE_T2, '0, '0, '0);
      send_record(SPECIAL_CHANNEL, '0, '0, '0);
      send_record(SPECIAL_CHANNEL, MAX_TAG, MAX_DELAY, MAX_SYNC);
      send_record(4'd5, MAX_TAG, MAX_DELAY, MAX_SYNC);    // photon scaled to zero

      // T2, full mask: only an all-ones tag is a marker; products wrap past 64 bits
      write_config(MODE_T2, MAX_WORD, 32'd1, MAX_MASK);
      send_record(SPECIAL_CHANNEL, MAX_TAG, '0, '0);
      send_record(SPECIAL_CHANNEL, MAX_TAG - 1, '0, '0);
      send_record(SPECIAL_CHANNEL, '0, '0, '0);
      send_record(4'd13, MAX_TAG, '0, '0);

      // random phases: the first two pin the register extremes, the rest draw settings
      for (int unsigned phase = 0; phase < PHASES; phase++) begin
         case ($urandom_range(0, 4))
            0:       res = '0;
            1:       res = 32'd1;
            2:       res = MAX_WORD;
            default: res = $urandom();
         endcase
         case ($urandom_range(0, 5))
            0:       step = '0;
            1:       step = 32'd1;
            2:       step = MAX_WORD;
            3:       step = $urandom_range(2, 1000);
            default: step = $urandom();
         endcase
         case ($urandom_range(0, 4))
            0:       mask = '0;
            1:       mask = MAX_MASK;
            2:       mask = MASK_RESET;
            3:       mask = MASK_W'($urandom() & $urandom() & $urandom());
            default: mask = MASK_W'($urandom());
         endcase
         if (phase == 0) begin
            write_config(MODE_T2, MAX_WORD, MAX_WORD, MAX_MASK);
         end else if (phase == 1) begin
            write_config(MODE_T3, '0, '0, '0);
         end else begin
            write_config(mode_type'(phase[0]), res, step, mask);
         end
         run_phase(RANDOM_ITEMS / PHASES);
      end

      // drain, then give any stray result time to show up
      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("sent %0d records under %0d register settings in T2 and T3 formats",
               items_sent, settings_used);
      $display("checked %0d photons, %0d markers and %0d overflows",
               photons_seen, markers_seen, overflows_seen);
      if (mismatch_count == 0 && results_owed == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

/* tttr_record_decoder_core.f */
design/tttr_dec_pkg.sv
design/tttr_dec_req_if.sv
design/tttr_dec_rsp_if.sv
design/tttr_dec_front.sv
design/tttr_dec_mul.sv
design/tttr_dec_fifo.sv
design/tttr_record_decoder_core.sv
dv/tttr_record_decoder_checker.sv
dv/tttr_record_decoder_core_tb.sv
